@@ rtl/assert_macros.svh @@
// Assertion helpers, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/dbvs_pkg.sv @@
`default_nettype none
package dbvs_pkg;
  localparam int MaxOrig   = 1024;
  localparam int MaxVirt   = 4096;
  localparam int MaxLayers = 16;
  localparam int OrigAw    = $clog2(MaxOrig);
  localparam int VirtAw    = $clog2(MaxVirt);
  localparam int CntW      = VirtAw + 1;
  localparam int LayerW    = $clog2(MaxLayers + 2);
  localparam int OvcW      = 11;
  localparam int DegW      = 8;
  localparam int GidW      = 32;

  localparam logic [1:0] RegOvc   = 2'd0;
  localparam logic [1:0] RegBound = 2'd1;
  localparam logic [1:0] RegRev   = 2'd2;
  localparam logic [1:0] RegGid   = 2'd3;

  typedef struct packed {
    logic [OvcW-1:0] ovc;
    logic [DegW-1:0] bound;
    logic            rev;
    logic [GidW-1:0] gid_start;
    logic            ld_local;
    logic            ld_global;
  } cfg_t;

  function automatic logic [DegW-1:0] sat_inc(input logic [DegW-1:0] d);
    sat_inc = (d == {DegW{1'b1}}) ? d : d + DegW'(1);
  endfunction
endpackage
`default_nettype wire

@@ rtl/dbvs_ram.sv @@
`default_nettype none
module dbvs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/dbvs_ctrl.sv @@
`default_nettype none
module dbvs_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dbvs_pkg::cfg_t                cfg_i,
  input  wire logic                          start_i,
  input  wire logic [dbvs_pkg::OrigAw-1:0]   vertex_id_i,
  output logic                               busy_o,
  output logic                               res_valid_o,
  output logic                               is_edge_o,
  output logic [dbvs_pkg::GidW-1:0]          edge_source_o,
  output logic [dbvs_pkg::GidW-1:0]          edge_target_o,
  output logic [dbvs_pkg::GidW-1:0]          representative_global_o,
  output logic                               out_of_vertices_o,
  output logic                               last_o
);
  localparam int OAW = dbvs_pkg::OrigAw;
  localparam int VAW = dbvs_pkg::VirtAw;
  localparam int CW  = dbvs_pkg::CntW;
  localparam int LW  = dbvs_pkg::LayerW;
  localparam int DW  = dbvs_pkg::DegW;
  localparam int GW  = dbvs_pkg::GidW;
  localparam int ZW  = 5;
  localparam int OvcLim = dbvs_pkg::OvcW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDU, S_RDU2, S_RDW, S_CHK, S_DECIDE,
    S_ALLOC1, S_ALLOC2, S_DESC, S_FINAL
  } state_e;

  state_e           state_q;
  logic [CW-1:0]    clr_q, nl_q;
  logic [GW-1:0]    ng_q;
  logic [OAW-1:0]   u_q;
  logic [VAW-1:0]   w_q, rep_u_q, wold_q;
  logic [VAW-1:0]   wpar_q;
  logic [ZW-1:0]    wdep_q;
  logic [DW-1:0]    wdeg_q, olddeg_q;
  logic [GW-1:0]    wgid_q;
  logic [LW-1:0]    layers_q, cnt_q;
  logic             newroot_q, nodesc_q, oov_q;

  logic [VAW-1:0]   rep_rd, par_rd;
  logic [ZW-1:0]    lay_rd, dep_rd;
  logic [DW-1:0]    deg_rd;
  logic [GW-1:0]    gid_rd;

  logic             rep_we, lay_we, v_we, deg_we;
  logic [OAW-1:0]   o_waddr;
  logic [VAW-1:0]   rep_wd, v_waddr, par_wd, deg_waddr;
  logic [ZW-1:0]    lay_wd, dep_wd;
  logic [DW-1:0]    deg_wd;
  logic [GW-1:0]    gid_wd;
  logic             clr_orig;
  logic [OvcLim-1:0] limit;
  logic             store_full;

  assign clr_orig   = clr_q < CW'(dbvs_pkg::MaxOrig);
  assign store_full = nl_q >= CW'(dbvs_pkg::MaxVirt);
  assign limit      = (cfg_i.ovc > OvcLim'(dbvs_pkg::MaxOrig)) ?
                      OvcLim'(dbvs_pkg::MaxOrig) : cfg_i.ovc;
  assign busy_o     = state_q != S_IDLE;

  always_comb begin
    rep_we = 1'b0; lay_we = 1'b0; v_we = 1'b0; deg_we = 1'b0;
    o_waddr = u_q; rep_wd = w_q; lay_wd = ZW'(layers_q) + ZW'(1);
    v_waddr = nl_q[VAW-1:0];
    par_wd = newroot_q ? nl_q[VAW-1:0] : w_q;
    dep_wd = newroot_q ? '0 : wdep_q + ZW'(1);
    gid_wd = ng_q;
    deg_waddr = nl_q[VAW-1:0]; deg_wd = '0;
    case (state_q)
      S_CLEAR: begin
        rep_we = clr_orig; lay_we = clr_orig; v_we = 1'b1; deg_we = 1'b1;
        o_waddr = clr_q[OAW-1:0]; rep_wd = clr_q[VAW-1:0]; lay_wd = '0;
        v_waddr = clr_q[VAW-1:0];
        par_wd = clr_orig ? clr_q[VAW-1:0] : '0;
        dep_wd = '0;
        gid_wd = clr_orig ? GW'(clr_q) : '0;
        deg_waddr = clr_q[VAW-1:0];
      end
      S_ALLOC1: begin
        v_we = 1'b1; deg_we = 1'b1; lay_we = newroot_q;
      end
      S_ALLOC2: begin
        deg_we = 1'b1; deg_waddr = wold_q; deg_wd = dbvs_pkg::sat_inc(olddeg_q);
      end
      S_FINAL: begin
        rep_we = 1'b1; deg_we = 1'b1; deg_waddr = w_q;
        deg_wd = dbvs_pkg::sat_inc(wdeg_q);
      end
      default: begin
      end
    endcase
  end

  dbvs_ram #(.Width(VAW), .Depth(dbvs_pkg::MaxOrig)) u_rep (
    .clk_i, .we_i(rep_we), .waddr_i(o_waddr), .wdata_i(rep_wd),
    .raddr_i(u_q), .rdata_o(rep_rd));
  dbvs_ram #(.Width(ZW), .Depth(dbvs_pkg::MaxOrig)) u_lay (
    .clk_i, .we_i(lay_we), .waddr_i(o_waddr), .wdata_i(lay_wd),
    .raddr_i(u_q), .rdata_o(lay_rd));
  dbvs_ram #(.Width(VAW), .Depth(dbvs_pkg::MaxVirt)) u_par (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(par_wd),
    .raddr_i(w_q), .rdata_o(par_rd));
  dbvs_ram #(.Width(ZW), .Depth(dbvs_pkg::MaxVirt)) u_dep (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(dep_wd),
    .raddr_i(w_q), .rdata_o(dep_rd));
  dbvs_ram #(.Width(GW), .Depth(dbvs_pkg::MaxVirt)) u_gid (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(gid_wd),
    .raddr_i(w_q), .rdata_o(gid_rd));
  dbvs_ram #(.Width(DW), .Depth(dbvs_pkg::MaxVirt)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wd),
    .raddr_i(w_q), .rdata_o(deg_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      nl_q <= CW'(dbvs_pkg::MaxOrig);
      ng_q <= '0;
      res_valid_o <= 1'b0;
      u_q <= '0; w_q <= '0; rep_u_q <= '0; wold_q <= '0; wpar_q <= '0;
      wdep_q <= '0; wdeg_q <= '0; olddeg_q <= '0; wgid_q <= '0;
      layers_q <= '0; cnt_q <= '0;
      newroot_q <= 1'b0; nodesc_q <= 1'b0; oov_q <= 1'b0;
      is_edge_o <= 1'b0; edge_source_o <= '0; edge_target_o <= '0;
      representative_global_o <= '0; out_of_vertices_o <= 1'b0; last_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_i.ld_local)  nl_q <= CW'(cfg_i.ovc);
      if (cfg_i.ld_global) ng_q <= cfg_i.gid_start;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CW'(1);
          if (clr_q == CW'(dbvs_pkg::MaxVirt - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i && ({1'b0, vertex_id_i} < limit)) begin
            u_q <= vertex_id_i;
            oov_q <= 1'b0; nodesc_q <= 1'b0; newroot_q <= 1'b0;
            cnt_q <= '0;
            state_q <= S_RDU;
          end
        end
        S_RDU: state_q <= S_RDU2;
        S_RDU2: begin
          w_q <= rep_rd; rep_u_q <= rep_rd; layers_q <= LW'(lay_rd);
          state_q <= S_RDW;
        end
        S_RDW: state_q <= S_CHK;
        S_CHK: begin
          wpar_q <= par_rd; wdep_q <= dep_rd; wdeg_q <= deg_rd; wgid_q <= gid_rd;
          if (nodesc_q) begin
            state_q <= S_FINAL;
          end else if (cnt_q <= LW'(dbvs_pkg::MaxLayers) && par_rd != w_q &&
                       deg_rd == cfg_i.bound) begin
            w_q <= par_rd; cnt_q <= cnt_q + LW'(1);
            state_q <= S_RDW;
          end else begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cnt_q <= '0;
          if (wpar_q == w_q && wdeg_q == cfg_i.bound) begin
            if (layers_q >= LW'(dbvs_pkg::MaxLayers)) begin
              nodesc_q <= 1'b1; w_q <= rep_u_q; state_q <= S_RDW;
            end else if (store_full) begin
              oov_q <= 1'b1; state_q <= S_FINAL;
            end else begin
              newroot_q <= 1'b1; state_q <= S_ALLOC1;
            end
          end else begin
            state_q <= S_DESC;
          end
        end
        S_ALLOC1: begin
          res_valid_o <= 1'b1; is_edge_o <= 1'b1; last_o <= 1'b0;
          out_of_vertices_o <= 1'b0; representative_global_o <= '0;
          edge_source_o <= cfg_i.rev ? ng_q : wgid_q;
          edge_target_o <= cfg_i.rev ? wgid_q : ng_q;
          wold_q <= w_q; olddeg_q <= wdeg_q;
          w_q <= nl_q[VAW-1:0];
          wdep_q <= dep_wd; wdeg_q <= '0; wgid_q <= ng_q;
          nl_q <= nl_q + CW'(1); ng_q <= ng_q + GW'(1);
          if (newroot_q) layers_q <= layers_q + LW'(1);
          else cnt_q <= cnt_q + LW'(1);
          newroot_q <= 1'b0;
          state_q <= S_ALLOC2;
        end
        S_ALLOC2: state_q <= S_DESC;
        S_DESC: begin
          if (cnt_q < LW'(dbvs_pkg::MaxLayers) && LW'(wdep_q) < layers_q) begin
            if (store_full) begin
              oov_q <= 1'b1; state_q <= S_FINAL;
            end else begin
              state_q <= S_ALLOC1;
            end
          end else begin
            state_q <= S_FINAL;
          end
        end
        S_FINAL: begin
          res_valid_o <= 1'b1; is_edge_o <= 1'b0; last_o <= 1'b1;
          edge_source_o <= '0; edge_target_o <= '0;
          representative_global_o <= wgid_q; out_of_vertices_o <= oov_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/degree_bounded_vertex_splitter_top.sv @@
// Reaching the layer limit makes the walk reread from the representative.
// One item at a time: a new vertex is accepted only while the sequencer is idle.
// Each walk step waits for a registered memory read; each allocation passes S_ALLOC1, S_ALLOC2 and S_DESC.
// Reset: asynchronous, active low; then all 4096 virtual entries are cleared, with busy high.
// Results cannot be stalled: each word is valid for exactly one cycle.
`default_nettype none
`include "assert_macros.svh"
module degree_bounded_vertex_splitter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [9:0]  vertex_id_i,
  output logic             result_valid_o,
  output logic             is_edge_o,
  output logic [31:0]      edge_source_o,
  output logic [31:0]      edge_target_o,
  output logic [31:0]      representative_global_o,
  output logic             out_of_vertices_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  // Configuration registers; writes to the OVC and GID registers also reload the allocation counters.
  dbvs_pkg::cfg_t   cfg;
  logic [10:0]      ovc_q;
  logic [7:0]       bound_q;
  logic             rev_q;
  logic [31:0]      gid_q;
  logic             wr;
  logic [1:0]       idx;

  assign pready = 1'b1;
  assign wr  = psel && penable && pwrite && pready;
  assign idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovc_q <= 11'd1024; bound_q <= 8'd2; rev_q <= 1'b0; gid_q <= '0;
    end else if (wr) begin
      case (idx)
        dbvs_pkg::RegOvc:   ovc_q   <= pwdata[10:0];
        dbvs_pkg::RegBound: bound_q <= pwdata[7:0];
        dbvs_pkg::RegRev:   rev_q   <= pwdata[0];
        dbvs_pkg::RegGid:   gid_q   <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      dbvs_pkg::RegOvc:   prdata = {21'd0, ovc_q};
      dbvs_pkg::RegBound: prdata = {24'd0, bound_q};
      dbvs_pkg::RegRev:   prdata = {31'd0, rev_q};
      dbvs_pkg::RegGid:   prdata = gid_q;
      default:            prdata = '0;
    endcase
  end

  // The load strobes reach the sequencer in the same cycle as the write,
  // so the counters take the written values at the same edge as the registers, unless an allocation advances them.
  always_comb begin
    cfg.ovc       = ovc_q;
    cfg.bound     = bound_q;
    cfg.rev       = rev_q;
    cfg.gid_start = pwdata;
    cfg.ld_local  = 1'b0;
    cfg.ld_global = 1'b0;
    if (wr && idx == dbvs_pkg::RegGid) cfg.ld_global = 1'b1;
    if (wr && idx == dbvs_pkg::RegOvc) cfg.ld_local = 1'b1;
    if (cfg.ld_local) cfg.ovc = pwdata[10:0];
  end

  dbvs_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg), .start_i(start), .vertex_id_i,
    .busy_o(busy), .res_valid_o(result_valid_o), .is_edge_o,
    .edge_source_o, .edge_target_o, .representative_global_o,
    .out_of_vertices_o, .last_o);

  // The final word leaves the sequencer idle; edge words come while it still works.
  `ASSERT_IMPL(a_final_idle, clk_i, rst_ni, result_valid_o && last_o, !busy)
  `ASSERT_IMPL(a_edge_busy, clk_i, rst_ni, result_valid_o && !last_o, busy && is_edge_o)
  `ASSERT_IMPL(a_oov_final, clk_i, rst_ni, result_valid_o && out_of_vertices_o,
               last_o && !is_edge_o)
  `ASSERT_NEXT(a_no_new_busy, clk_i, rst_ni, !busy && !start, !result_valid_o)
endmodule
`default_nettype wire
